// ===== hdl/multitone_cosine_synth_macros.svh =====
// Assertion macros shared by the multitone cosine synthesizer RTL.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef MULTITONE_COSINE_SYNTH_MACROS_SVH
`define MULTITONE_COSINE_SYNTH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mcs_pkg.sv =====
// Shared constants, types and the cosine table generator for the multitone synthesizer.
// No dependencies; the files that use it refer to this package by scoped names.
`default_nettype none

package mcs_pkg;

    localparam int SAMPLE_TIME_W   = 32;
    localparam int SAMPLE_VALUE_W  = 34;
    localparam int SETTINGS_W      = 64;
    localparam int TONE_COUNT_W    = 3;
    localparam int AMP_W           = 16;
    localparam int COS_W           = 16;
    localparam int PROD_W          = AMP_W + COS_W;
    localparam int S_TDATA_W       = 32;
    localparam int M_TDATA_W       = 40;

    localparam int DEFAULT_MAX_TONES       = 4;
    localparam int DEFAULT_COS_TABLE_DEPTH = 1024;

    // Register indexes on the configuration port.
    localparam int REG_TONE_COUNT = 0;
    localparam int REG_TONE0      = 1;

    // Field positions inside one tone settings word.
    localparam int FREQ_LSB  = 0;
    localparam int AMP_LSB   = 32;
    localparam int PHASE_LSB = 48;

    localparam logic [63:0] TWO_PI_Q44 = 64'd110534964875448;
    localparam logic [63:0] Q30_ONE    = 64'd1073741824;
    localparam int          TAYLOR_TERMS = 12;
    // Divisors (2n-1)*2n of the cosine series, one per term.
    localparam logic [63:0] TAYLOR_DIV [1:12] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
    };

    // Control from the sequencer to the tone datapath.
    typedef struct packed {
        logic clear;        // start of a new item: zero the accumulator
        logic issue;        // a settings read for one tone is launched this cycle
        logic entry_valid;  // settings entry being returned was written since reset
    } mcs_ctrl_t;

    // Status from the tone datapath back to the sequencer.
    typedef struct packed {
        logic busy;         // some tone is still in flight
    } mcs_stat_t;

    // Cosine of m table steps within the first quadrant, Q15 magnitude.
    // Elaboration only: builds the constant table in the cosine ROM.
    function automatic logic [15:0] quarter_cos(input logic [31:0] m, input int unsigned aw);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        logic [63:0] v;
        x    = (((64'(m) * TWO_PI_Q44) >> aw) + 64'd8192) >> 14;
        x2   = (x * x) >> 30;
        term = Q30_ONE;
        sum  = longint'(Q30_ONE);
        for (int n = 1; n <= TAYLOR_TERMS; n++)
        begin
            term = (term * x2) >> 30;
            term = term / TAYLOR_DIV[n];
            if (n[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(Q30_ONE))
            sum = longint'(Q30_ONE);
        v = ((64'(sum) * 64'd32768) + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return v[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/multitone_cosine_synth.sv =====
// Multitone cosine synthesizer: each input item carries a sample time and yields one output item,
// the exact sum of amplitude times cosine over the active tones (1 to MAX_TONES, or none). An
// item is accepted only after the previous result is loaded into the output register. Tones are
// launched one per cycle from the tone settings RAM into a four-stage phase, cosine ROM, multiply
// and accumulate pipeline, which then drains before the result is loaded into the output
// register. The load waits while the previous result still sits unaccepted in that register,
// which lengthens the item. A new item is accepted while the previous result still waits in
// that register.
// Depends on mcs_pkg, mcs_ram, mcs_tone_path and the assertion macro header.
`default_nettype none

`include "multitone_cosine_synth_macros.svh"

module multitone_cosine_synth #(
    parameter int MAX_TONES       = mcs_pkg::DEFAULT_MAX_TONES,
    parameter int COS_TABLE_DEPTH = mcs_pkg::DEFAULT_COS_TABLE_DEPTH,
    localparam int IXW            = $clog2(MAX_TONES + 1)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [mcs_pkg::S_TDATA_W-1:0]     s_tdata,   // [31:0] sample_time
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [mcs_pkg::M_TDATA_W-1:0]     m_tdata,   // [33:0] sample_value, [39:34] zero
    input  wire logic                              cfg_wr_en,
    input  wire logic [IXW-1:0]                    cfg_index,
    input  wire logic [mcs_pkg::SETTINGS_W-1:0]    cfg_wdata
);

    localparam int TIW  = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
    localparam int CNTW = $clog2(MAX_TONES + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t                                       state_reg;
    state_t                                       state_next;
    logic [CNTW-1:0]                              count_reg;
    logic [MAX_TONES-1:0]                         set_valid_reg;
    logic [TIW-1:0]                               tone_idx_reg;
    logic [TIW-1:0]                               tone_idx_next;
    logic [mcs_pkg::SAMPLE_TIME_W-1:0]            sample_time_reg;
    logic                                         m_tvalid_reg;
    logic signed [mcs_pkg::SAMPLE_VALUE_W-1:0]    out_reg;
    logic                                         accept;
    logic                                         last_tone;
    logic                                         out_load;
    logic                                         set_we;
    logic [TIW-1:0]                               set_waddr;
    logic [mcs_pkg::SETTINGS_W-1:0]               rd_data;
    logic signed [mcs_pkg::SAMPLE_VALUE_W-1:0]    acc;
    mcs_pkg::mcs_ctrl_t                           ctrl;
    mcs_pkg::mcs_stat_t                           stat;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign last_tone = (32'(tone_idx_reg) + 1) == 32'(count_reg);
    assign out_load  = (state_reg == ST_DRAIN) && !stat.busy && (!m_tvalid_reg || m_tready);

    assign set_we    = cfg_wr_en && (32'(cfg_index) >= mcs_pkg::REG_TONE0)
                       && (32'(cfg_index) <= MAX_TONES);
    assign set_waddr = TIW'(32'(cfg_index) - mcs_pkg::REG_TONE0);

    assign ctrl.clear       = accept;
    assign ctrl.issue       = (state_reg == ST_RUN);
    assign ctrl.entry_valid = set_valid_reg[tone_idx_reg];

    always_comb
    begin
        state_next    = state_reg;
        tone_idx_next = tone_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                tone_idx_next = '0;
                if (accept)
                    state_next = (count_reg == '0) ? ST_DRAIN : ST_RUN;
            end
            ST_RUN:
            begin
                tone_idx_next = tone_idx_reg + TIW'(1);
                if (last_tone)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tone_idx_reg  <= '0;
            count_reg     <= '0;
            set_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tone_idx_reg <= tone_idx_next;
            if (cfg_wr_en && (32'(cfg_index) == mcs_pkg::REG_TONE_COUNT))
            begin
                // Counts above the number of tone slots saturate.
                if (32'(cfg_wdata[mcs_pkg::TONE_COUNT_W-1:0]) > MAX_TONES)
                    count_reg <= CNTW'(MAX_TONES);
                else
                    count_reg <= CNTW'(cfg_wdata[mcs_pkg::TONE_COUNT_W-1:0]);
            end
            if (set_we)
                set_valid_reg[set_waddr] <= 1'b1;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            sample_time_reg <= s_tdata[mcs_pkg::SAMPLE_TIME_W-1:0];
        if (out_load)
            out_reg <= acc;
    end

    mcs_ram #(
        .WIDTH (mcs_pkg::SETTINGS_W),
        .DEPTH (MAX_TONES)
    ) u_settings_ram (
        .clk   (clk),
        .we    (set_we),
        .waddr (set_waddr),
        .wdata (cfg_wdata),
        .re    (ctrl.issue),
        .raddr (tone_idx_reg),
        .rdata (rd_data)
    );

    mcs_tone_path #(
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_tone_path (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .sample_time (sample_time_reg),
        .rd_data     (rd_data),
        .stat        (stat),
        .acc         (acc)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(mcs_pkg::M_TDATA_W - mcs_pkg::SAMPLE_VALUE_W){1'b0}}, out_reg};

    `MCS_ASSERT_NOW(a_idle_pipe_empty, s_tready, !stat.busy, "item accepted while tones in flight")
    `MCS_ASSERT_NOW(a_idx_in_range, state_reg == ST_RUN, 32'(tone_idx_reg) < 32'(count_reg), "tone index beyond active count")
    `MCS_ASSERT_NEXT(a_accept_starts, accept, state_reg == ST_RUN || state_reg == ST_DRAIN, "accepted item did not start")

endmodule

`default_nettype wire

// ===== hdl/mcs_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module mcs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic                 re,
    input  wire logic [AW-1:0]        raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/mcs_cos_rom.sv =====
// Full-period cosine lookup built from a quarter-wave table with registered output.
// Depends on mcs_pkg for the table generator.
`default_nettype none

module mcs_cos_rom #(
    parameter int DEPTH = mcs_pkg::DEFAULT_COS_TABLE_DEPTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic [AW-1:0]                    addr,
    output logic signed [mcs_pkg::COS_W-1:0]      cos_val
);

    localparam int QUARTER = DEPTH / 4;

    typedef logic [mcs_pkg::COS_W-1:0] qtab_t [QUARTER+1];

    function automatic qtab_t build_tab();
        qtab_t tab;
        for (int k = 0; k <= QUARTER; k++)
            tab[k] = mcs_pkg::quarter_cos(32'(k), AW);
        return tab;
    endfunction

    localparam qtab_t QTAB = build_tab();

    logic [1:0]                     quad;
    logic [AW-3:0]                  rem;
    logic [AW-2:0]                  fold;
    logic                           negate;
    logic [mcs_pkg::COS_W-1:0]      mag;
    logic signed [mcs_pkg::COS_W-1:0] cos_reg;

    // Quadrants one and three mirror the table; quadrants one and two are negative.
    assign quad   = addr[AW-1 -: 2];
    assign rem    = addr[AW-3:0];
    assign fold   = quad[0] ? (AW-1)'(QUARTER - 32'(rem)) : {1'b0, rem};
    assign negate = quad[0] ^ quad[1];
    assign mag    = QTAB[fold];

    always_ff @(posedge clk)
    begin
        if (en)
            cos_reg <= negate ? -$signed(mag) : $signed(mag);
    end

    assign cos_val = cos_reg;

endmodule

`default_nettype wire

// ===== hdl/mcs_tone_path.sv =====
// Per-tone datapath: phase multiply, cosine lookup, amplitude multiply and accumulate.
// Depends on mcs_pkg and mcs_cos_rom.
`default_nettype none

module mcs_tone_path #(
    parameter int COS_TABLE_DEPTH = mcs_pkg::DEFAULT_COS_TABLE_DEPTH
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire mcs_pkg::mcs_ctrl_t                      ctrl,
    input  wire logic [mcs_pkg::SAMPLE_TIME_W-1:0]       sample_time,
    input  wire logic [mcs_pkg::SETTINGS_W-1:0]          rd_data,
    output mcs_pkg::mcs_stat_t                           stat,
    output logic signed [mcs_pkg::SAMPLE_VALUE_W-1:0]    acc
);

    localparam int AW = $clog2(COS_TABLE_DEPTH);

    logic                                  v_rd_reg;
    logic                                  v_ph_reg;
    logic                                  v_rom_reg;
    logic                                  v_prod_reg;
    logic                                  entry_valid_reg;
    logic [mcs_pkg::SETTINGS_W-1:0]        settings;
    logic [31:0]                           ft;
    logic [31:0]                           phase_next;
    logic [31:0]                           phase_reg;
    logic signed [mcs_pkg::AMP_W-1:0]      amp_reg;
    logic signed [mcs_pkg::AMP_W-1:0]      amp_d_reg;
    logic signed [mcs_pkg::COS_W-1:0]      cos_val;
    logic signed [mcs_pkg::PROD_W-1:0]     prod_reg;
    logic signed [mcs_pkg::SAMPLE_VALUE_W-1:0] acc_reg;

    // An entry never written since reset reads as all zeros.
    assign settings   = entry_valid_reg ? rd_data : '0;
    assign ft         = settings[mcs_pkg::FREQ_LSB +: 32] * sample_time;
    assign phase_next = ft - {settings[mcs_pkg::PHASE_LSB +: 16], 16'h0000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_rd_reg   <= 1'b0;
            v_ph_reg   <= 1'b0;
            v_rom_reg  <= 1'b0;
            v_prod_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            v_rd_reg   <= ctrl.issue;
            v_ph_reg   <= v_rd_reg;
            v_rom_reg  <= v_ph_reg;
            v_prod_reg <= v_rom_reg;
            if (ctrl.clear)
                acc_reg <= '0;
            else if (v_prod_reg)
                acc_reg <= acc_reg + {{(mcs_pkg::SAMPLE_VALUE_W - mcs_pkg::PROD_W){prod_reg[mcs_pkg::PROD_W-1]}}, prod_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        entry_valid_reg <= ctrl.entry_valid;
        if (v_rd_reg)
        begin
            phase_reg <= phase_next;
            amp_reg   <= $signed(settings[mcs_pkg::AMP_LSB +: mcs_pkg::AMP_W]);
        end
        if (v_ph_reg)
            amp_d_reg <= amp_reg;
        if (v_rom_reg)
            prod_reg <= amp_d_reg * cos_val;
    end

    mcs_cos_rom #(
        .DEPTH (COS_TABLE_DEPTH)
    ) u_cos_rom (
        .clk     (clk),
        .en      (v_ph_reg),
        .addr    (phase_reg[31 -: AW]),
        .cos_val (cos_val)
    );

    assign stat.busy = v_rd_reg | v_ph_reg | v_rom_reg | v_prod_reg;
    assign acc       = acc_reg;

endmodule

`default_nettype wire

// ===== tb/mcs_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the multitone cosine synthesizer: tracks register writes, predicts the sum
// of every accepted sample time and compares it with the output stream in order.
// Depends on mcs_pkg for widths, register indexes and settings field positions.

module mcs_checker #(
    parameter int NUM_TONES = 4,
    parameter int ROM_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [mcs_pkg::S_TDATA_W-1:0]     s_tdata,   // [31:0] sample_time
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [mcs_pkg::M_TDATA_W-1:0]     m_tdata,   // [33:0] sample_value, [39:34] zero
    input  logic                              cfg_wr_en,
    input  logic [2:0]                        cfg_index,
    input  logic [mcs_pkg::SETTINGS_W-1:0]    cfg_wdata,
    output int                                mismatch_count,
    output int                                pending_count,
    output int                                results_checked
);

    localparam int ROM_AW  = $clog2(ROM_DEPTH);
    localparam int QUARTER = ROM_DEPTH / 4;
    localparam int PAD_W   = mcs_pkg::M_TDATA_W - mcs_pkg::SAMPLE_VALUE_W;
    localparam logic [63:0] ANGLE_FULL_TURN = 64'd110534964875448;   // 2*pi in Q44
    localparam logic [63:0] UNITY_Q30       = 64'd1073741824;
    localparam int          SERIES_TERMS    = 12;

    typedef struct {
        logic [31:0]                          sample_time;
        logic [mcs_pkg::SAMPLE_VALUE_W-1:0]   value;
    } sample_rec_t;

    int          cos_rom [ROM_DEPTH];
    logic [2:0]  tone_count_q;
    logic [63:0] tone_word [NUM_TONES];
    sample_rec_t awaited [$];

    // Q15 cosine of m table steps inside the first quadrant, built from a truncated series.
    function automatic int quarter_cosine(input int unsigned m);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] v;
        longint      acc;
        x    = (((64'(m) * ANGLE_FULL_TURN) >> ROM_AW) + 64'd8192) >> 14;
        x2   = (x * x) >> 30;
        term = UNITY_Q30;
        acc  = longint'(UNITY_Q30);
        for (int n = 1; n <= SERIES_TERMS; n++)
        begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > longint'(UNITY_Q30))
            acc = longint'(UNITY_Q30);
        v = (($unsigned(acc) * 64'd32768) + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return int'(v);
    endfunction

    function automatic logic [mcs_pkg::SAMPLE_VALUE_W-1:0] synth_sample(input logic [31:0] t);
        logic [63:0]        word;
        logic [31:0]        freq;
        logic [31:0]        phase_acc;
        logic signed [15:0] amp;
        logic [15:0]        ph;
        int                 active;
        longint             total;
        active = (int'(tone_count_q) > NUM_TONES) ? NUM_TONES : int'(tone_count_q);
        total  = 0;
        for (int i = 0; i < active; i++)
        begin
            word      = tone_word[i];
            freq      = word[mcs_pkg::FREQ_LSB +: 32];
            amp       = word[mcs_pkg::AMP_LSB +: 16];
            ph        = word[mcs_pkg::PHASE_LSB +: 16];
            phase_acc = freq * t - {ph, 16'h0000};
            total     = total + longint'(amp) * longint'(cos_rom[phase_acc[31 -: ROM_AW]]);
        end
        return total[mcs_pkg::SAMPLE_VALUE_W-1:0];
    endfunction

    initial
    begin
        int q;
        int r;
        for (int k = 0; k < ROM_DEPTH; k++)
        begin
            q = k / QUARTER;
            r = k % QUARTER;
            case (q)
                0:       cos_rom[k] = quarter_cosine(r);
                1:       cos_rom[k] = -quarter_cosine(QUARTER - r);
                2:       cos_rom[k] = -quarter_cosine(r);
                default: cos_rom[k] = quarter_cosine(QUARTER - r);
            endcase
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        sample_rec_t rec;
        if (!rst_n)
        begin
            tone_count_q <= '0;
            for (int i = 0; i < NUM_TONES; i++)
                tone_word[i] <= '0;
            awaited.delete();
            mismatch_count  = 0;
            results_checked = 0;
            pending_count  <= 0;
        end
        else
        begin
            // Indexes past the last tone are not registers and leave the state alone.
            if (cfg_wr_en)
            begin
                if (int'(cfg_index) == mcs_pkg::REG_TONE_COUNT)
                    tone_count_q <= cfg_wdata[2:0];
                else if (int'(cfg_index) >= mcs_pkg::REG_TONE0 &&
                         int'(cfg_index) < mcs_pkg::REG_TONE0 + NUM_TONES)
                    tone_word[int'(cfg_index) - mcs_pkg::REG_TONE0] <= cfg_wdata;
            end

            if (s_tvalid && s_tready)
            begin
                rec.sample_time = s_tdata[31:0];
                rec.value       = synth_sample(s_tdata[31:0]);
                awaited.push_back(rec);
            end

            if (m_tvalid && m_tready)
            begin
                if (awaited.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] unexpected output item, tdata %h", $time, m_tdata);
                end
                else
                begin
                    rec = awaited.pop_front();
                    results_checked++;
                    if (m_tdata !== {{PAD_W{1'b0}}, rec.value})
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("[%0t] sample time %h: expected %0d, got %0d (tdata %h)",
                                     $time, rec.sample_time, $signed(rec.value),
                                     $signed(m_tdata[mcs_pkg::SAMPLE_VALUE_W-1:0]), m_tdata);
                    end
                end
            end
            pending_count <= awaited.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the multitone cosine synthesizer testbench: clock, reset, register writes and
// sample-time items, with random stalls on both streams. Depends on mcs_pkg, mcs_checker and multitone_cosine_synth.

module tb_top;

    localparam int NUM_TONES     = mcs_pkg::DEFAULT_MAX_TONES;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_ITEMS   = 115;
    localparam int INDEX_SPAN    = 8;     // every code the 3-bit index can carry

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [mcs_pkg::S_TDATA_W-1:0]    s_tdata;   // [31:0] sample_time
    logic                             m_tvalid;
    logic                             m_tready;
    logic [mcs_pkg::M_TDATA_W-1:0]    m_tdata;   // [33:0] sample_value, [39:34] zero
    logic                             cfg_wr_en;
    logic [2:0]                       cfg_index;
    logic [mcs_pkg::SETTINGS_W-1:0]   cfg_wdata;

    int mismatch_count;
    int pending_count;
    int results_checked;
    int items_sent     = 0;
    int settings_used  = 0;
    int cycle_count    = 0;

    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;
    bit hold_req        = 1'b0;

    logic [63:0] plan_count;
    logic [63:0] plan_word [NUM_TONES];

    multitone_cosine_synth u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    mcs_checker #(
        .NUM_TONES (NUM_TONES),
        .ROM_DEPTH (mcs_pkg::DEFAULT_COS_TABLE_DEPTH)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .pending_count   (pending_count),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, pending_count);
            $display("FAIL multitone_cosine_synth");
            $finish;
        end
    end

    // Mostly no gap, often a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] pack_tone(input logic [31:0] freq, input logic [15:0] amp,
                                              input logic [15:0] ph);
        logic [63:0] word;
        word = '0;
        word[mcs_pkg::FREQ_LSB +: 32]  = freq;
        word[mcs_pkg::AMP_LSB +: 16]   = amp;
        word[mcs_pkg::PHASE_LSB +: 16] = ph;
        return word;
    endfunction

    function automatic logic [63:0] random_tone();
        logic [31:0] freq;
        logic [15:0] amp;
        logic [15:0] ph;
        case ($urandom_range(0, 9))
            0:       freq = '0;
            1:       freq = '1;
            2, 3:    freq = $urandom_range(0, 65535);
            4:       freq = 32'h1 << $urandom_range(0, 31);
            default: freq = $urandom;
        endcase
        case ($urandom_range(0, 7))
            0:       amp = 16'h8000;
            1:       amp = 16'h7FFF;
            2:       amp = 16'h0000;
            default: amp = 16'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       ph = 16'h0000;
            1:       ph = 16'hFFFF;
            default: ph = 16'($urandom);
        endcase
        return pack_tone(freq, amp, ph);
    endfunction

    // The count register keeps only its low three bits, so the rest of the word is noise.
    function automatic logic [63:0] random_count();
        logic [63:0] word;
        word = {$urandom, $urandom};
        if ($urandom_range(0, 2) != 0)
            word[63:3] = '0;
        word[2:0] = ($urandom_range(0, 9) < 5) ? 3'(NUM_TONES) : 3'($urandom_range(0, 7));
        return word;
    endfunction

    // Called only with both streams idle; the enable stays high across back-to-back writes.
    task automatic apply_plan(input bit write_tones, input bit with_stray);
        if (write_tones)
        begin
            for (int i = 0; i < NUM_TONES; i++)
            begin
                cfg_wr_en <= 1'b1;
                cfg_index <= 3'(mcs_pkg::REG_TONE0 + i);
                cfg_wdata <= plan_word[i];
                @(posedge clk);
            end
        end
        if (with_stray)
        begin
            for (int k = mcs_pkg::REG_TONE0 + NUM_TONES; k < INDEX_SPAN; k++)
            begin
                cfg_wr_en <= 1'b1;
                cfg_index <= 3'(k);
                cfg_wdata <= {$urandom, $urandom};
                @(posedge clk);
            end
        end
        cfg_wr_en <= 1'b1;
        cfg_index <= 3'(mcs_pkg::REG_TONE_COUNT);
        cfg_wdata <= plan_count;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic send_sample(input logic [31:0] t);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // The first edge lets the checker count the item accepted on the last one.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int len;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (receiver_steady)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                len = pick_gap();
                if (len > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (len) @(posedge clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [31:0] base;
        logic [31:0] stride;
        logic [31:0] t;
        int          style;

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No tones active after reset: every sum is zero.
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        wait_drained();

        // All tones active but their settings still at reset values.
        plan_count = 64'(NUM_TONES);
        apply_plan(1'b0, 1'b0);
        send_sample(32'h1234_5678);
        wait_drained();

        // Largest positive sum: full negative amplitude at the cosine's negative peak.
        // The count word is all ones, so the count saturates to the number of tones.
        for (int i = 0; i < NUM_TONES; i++)
            plan_word[i] = pack_tone(32'h0000_0000, 16'h8000, 16'h8000);
        plan_count = '1;
        apply_plan(1'b1, 1'b1);
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h8000_0000);
        wait_drained();

        // Largest negative sum, plus phase wrapping at the ends of the sample time.
        for (int i = 0; i < NUM_TONES; i++)
            plan_word[i] = pack_tone(32'hFFFF_FFFF, 16'h8000, 16'h0000);
        plan_count = 64'(NUM_TONES);
        apply_plan(1'b1, 1'b0);
        send_sample(32'h0000_0000);
        send_sample(32'h0000_0001);
        send_sample(32'hFFFF_FFFF);
        wait_drained();

        // Tone counts zero to six in turn, including the ones above the number of tones.
        plan_word[0] = pack_tone(32'h0100_0000, 16'h7FFF, 16'h0000);
        plan_word[1] = pack_tone(32'h8000_0000, 16'h8001, 16'h4000);
        plan_word[2] = pack_tone(32'h0000_0001, 16'h1234, 16'hFFFF);
        plan_word[3] = pack_tone(32'hDEAD_BEEF, 16'h8000, 16'h0001);
        for (int c = 0; c < INDEX_SPAN - 1; c++)
        begin
            plan_count = 64'(c);
            apply_plan(c == 0, 1'b0);
            send_sample(32'h0000_0040);
            send_sample($urandom);
            wait_drained();
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            sender_steady   = (p % 4 == 1) || (p % 8 == 2);
            receiver_steady = (p % 4 == 1);
            for (int i = 0; i < NUM_TONES; i++)
                plan_word[i] = random_tone();
            plan_count = random_count();
            apply_plan(1'b1, p % 5 == 0);
            // The output side freezes while items keep coming, so the block backs up.
            if (p % 8 == 2)
                hold_req = 1'b1;
            base   = $urandom;
            stride = $urandom_range(1, 16);
            style  = $urandom_range(0, 2);
            for (int j = 0; j < PHASE_ITEMS; j++)
            begin
                case (style)
                    0:       t = $urandom;
                    1:       t = base + 32'(j) * stride;
                    default: t = ($urandom_range(0, 1) != 0) ? $urandom : base + 32'(j);
                endcase
                send_sample(t);
            end
            wait_drained();
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        repeat (16) @(posedge clk);

        $display("Covered %0d sample times under %0d register settings, %0d sums checked",
                 items_sent, settings_used, results_checked);
        $display("with %0d mismatches and %0d results outstanding.", mismatch_count,
                 pending_count);
        if (mismatch_count == 0 && pending_count == 0)
            $display("PASS multitone_cosine_synth");
        else
            $display("FAIL multitone_cosine_synth");
        $finish;
    end

endmodule
